// ===== hw/rtl/tlt_pkg.sv =====
// Shared types and constants for the tilt angle CORDIC pipeline.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package tlt_pkg;

    localparam int AXIS_W   = 16;
    localparam int OUT_W    = 16;
    localparam int CORDIC_W = 28;  // x/y datapath, inputs scaled by 2^FRAC_BITS
    localparam int ACC_W    = 28;  // angle accumulator, 2^-16 degree units
    localparam int FRAC_BITS = 8;
    localparam int LUT_W    = 22;
    localparam int LUT_LEN  = 24;
    localparam int ROUND_SHIFT = 9;  // 2^-16 deg -> 2^-7 deg

    localparam logic signed [ACC_W-1:0] DEG90_Q16 = 28'sd5898240;
    localparam logic signed [OUT_W-1:0] DEG180_Q7 = 16'sd23040;

    // round(atan(2^-i) * 180/pi * 65536)
    localparam logic [LUT_W-1:0] ANGLE_LUT [LUT_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

    // Cases decided before the rotations, carried down the pipe.
    typedef enum logic [1:0] {
        SPEC_NONE,
        SPEC_ZERO,
        SPEC_HALF_TURN
    } spec_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlt_in_if.sv =====
// Input channel: one word is a pair of signed accelerometer axis readings.
// Depends on tlt_pkg for the field width.
`default_nettype none

interface tlt_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [tlt_pkg::AXIS_W-1:0]   axis_a;
    logic signed [tlt_pkg::AXIS_W-1:0]   axis_b;

    modport source (output valid, output axis_a, output axis_b, input ready);
    modport sink   (input valid, input axis_a, input axis_b, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tlt_out_if.sv =====
// Output channel: one word is a signed angle in 1/128 degree.
// Depends on tlt_pkg for the field width.
`default_nettype none

interface tlt_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [tlt_pkg::OUT_W-1:0]   angle_deg_q7;

    modport source (output valid, output angle_deg_q7, input ready);
    modport sink   (input valid, input angle_deg_q7, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tilt_angle_atan2_degrees.sv =====
// Four-quadrant atan2 in degrees by a pipelined vectoring CORDIC.
// Stages: one quadrant stage, one stage per micro-rotation, one rounding/output
// stage. Throughput one word per cycle while the skid entry is free.
// A two-entry output (register plus skid) decouples the pipe from the sink.
// rst_n asynchronously clears all valid bits; data registers are not reset.
// Depends on tlt_pkg, tlt_in_if, tlt_out_if.
`default_nettype none

module tilt_angle_atan2_degrees #(
    parameter int ITERATIONS = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    tlt_in_if.sink      samples,
    tlt_out_if.source   angles
);

    localparam int CW = tlt_pkg::CORDIC_W;
    localparam int AW = tlt_pkg::ACC_W;
    localparam int OW = tlt_pkg::OUT_W;
    localparam int SW = AW + 1;

    logic signed [CW-1:0] x_reg   [ITERATIONS+1];
    logic signed [CW-1:0] y_reg   [ITERATIONS+1];
    logic signed [AW-1:0] acc_reg [ITERATIONS+1];
    tlt_pkg::spec_t       spec_reg [ITERATIONS+1];
    logic [ITERATIONS:0]  v_reg;

    logic                 adv;
    logic                 skid_valid_reg;
    logic signed [OW-1:0] skid_reg;
    logic                 out_valid_reg;
    logic signed [OW-1:0] out_reg;

    // Pipe moves whenever the skid entry is free.
    assign adv           = !skid_valid_reg;
    assign samples.ready = adv;

    // ---------------- quadrant pre-rotation ----------------
    logic signed [16:0]   a17, b17, x17, y17;
    logic signed [CW-1:0] x0_next, y0_next;
    logic signed [AW-1:0] acc0_next;
    tlt_pkg::spec_t       spec0_next;

    always_comb
    begin
        a17 = 17'(samples.axis_a);
        b17 = 17'(samples.axis_b);
        if (b17 < 0)
        begin
            if (a17 >= 0)
            begin
                x17       = a17;
                y17       = -b17;
                acc0_next = tlt_pkg::DEG90_Q16;
            end
            else
            begin
                x17       = -a17;
                y17       = b17;
                acc0_next = -tlt_pkg::DEG90_Q16;
            end
        end
        else
        begin
            x17       = b17;
            y17       = a17;
            acc0_next = '0;
        end
        x0_next = CW'(x17) <<< tlt_pkg::FRAC_BITS;
        y0_next = CW'(y17) <<< tlt_pkg::FRAC_BITS;

        if (a17 == 0 && b17 == 0)
            spec0_next = tlt_pkg::SPEC_ZERO;
        else if (a17 == 0 && b17 < 0)
            spec0_next = tlt_pkg::SPEC_HALF_TURN;
        else
            spec0_next = tlt_pkg::SPEC_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            acc_reg[0]  <= acc0_next;
            spec_reg[0] <= spec0_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[ITERATIONS-1:0], samples.valid};
    end

    // ---------------- micro-rotations, one per stage ----------------
    for (genvar k = 0; k < ITERATIONS; k++)
    begin : g_rot
        logic signed [CW-1:0] xs, ys, x_next, y_next;
        logic signed [AW-1:0] step, acc_next;

        always_comb
        begin
            xs   = x_reg[k] >>> k;
            ys   = y_reg[k] >>> k;
            step = $signed({{(AW-tlt_pkg::LUT_W){1'b0}}, tlt_pkg::ANGLE_LUT[k]});
            if (!y_reg[k][CW-1])
            begin
                x_next   = x_reg[k] + ys;
                y_next   = y_reg[k] - xs;
                acc_next = acc_reg[k] + step;
            end
            else
            begin
                x_next   = x_reg[k] - ys;
                y_next   = y_reg[k] + xs;
                acc_next = acc_reg[k] - step;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[k+1]    <= x_next;
                y_reg[k+1]    <= y_next;
                acc_reg[k+1]  <= acc_next;
                spec_reg[k+1] <= spec_reg[k];
            end
        end
    end

    // ---------------- round, saturate, override ----------------
    logic signed [SW-1:0] rsum, rq;
    logic signed [OW-1:0] final_q;

    always_comb
    begin
        rsum = SW'(acc_reg[ITERATIONS]) + SW'(256);
        rq   = rsum >>> tlt_pkg::ROUND_SHIFT;
        if (rq > SW'(tlt_pkg::DEG180_Q7))
            final_q = tlt_pkg::DEG180_Q7;
        else if (rq < -SW'(tlt_pkg::DEG180_Q7))
            final_q = -tlt_pkg::DEG180_Q7;
        else
            final_q = rq[OW-1:0];

        case (spec_reg[ITERATIONS])
            tlt_pkg::SPEC_ZERO:      final_q = '0;
            tlt_pkg::SPEC_HALF_TURN: final_q = tlt_pkg::DEG180_Q7;
            default:                 ;
        endcase
    end

    // ---------------- output register + skid ----------------
    logic out_free;
    assign out_free = !out_valid_reg || angles.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= v_reg[ITERATIONS];
        end
        else if (adv && v_reg[ITERATIONS])
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_reg <= skid_valid_reg ? skid_reg : final_q;
        else if (adv && v_reg[ITERATIONS])
            skid_reg <= final_q;
    end

    assign angles.valid        = out_valid_reg;
    assign angles.angle_deg_q7 = out_reg;

endmodule

`default_nettype wire

// ===== sim/tilt_angle_atan2_degrees_tb.sv =====
// Self-checking testbench for the four-quadrant tilt angle CORDIC (atan2 in degrees).
// Depends on tlt_pkg, tlt_in_if, tlt_out_if and the tilt_angle_atan2_degrees top level.
`timescale 1ns / 100ps

module tilt_angle_atan2_degrees_tb;

    localparam int AXIS_W    = tlt_pkg::AXIS_W;
    localparam int OUT_W     = tlt_pkg::OUT_W;
    localparam int FRAC_BITS = tlt_pkg::FRAC_BITS;

    localparam int ITERS       = 16;
    localparam int PIPE_LAT    = ITERS + 2;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 5000;

    localparam longint ROT90_Q16  = 64'sd5898240;
    localparam longint HALF_TURN  = 64'sd23040;
    localparam int     ATAN_DEPTH = 24;

    // atan(2^-i) in 2^-16 degree
    localparam longint ATAN_STEP [ATAN_DEPTH] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic clk;
    logic rst_n;

    tlt_in_if  samples_if ();
    tlt_out_if angles_if ();

    tilt_angle_atan2_degrees #(
        .ITERATIONS (ITERS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .angles  (angles_if)
    );

    logic signed [OUT_W-1:0] expected_angles [$];

    int  errors;
    int  samples_sent;
    int  angles_checked;
    int  idle_cycles;
    bit  src_idle_en;
    bit  snk_idle_en;
    bit  hold_req;

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Angle of (ya, xb) in 1/128 degree, same fixed-point steps as the pipe.
    function automatic logic signed [OUT_W-1:0] atan2_q7(
        input logic signed [AXIS_W-1:0] ya,
        input logic signed [AXIS_W-1:0] xb
    );
        longint y_in;
        longint x_in;
        longint x;
        longint y;
        longint acc;
        longint nx;
        longint ny;
        longint q;
        y_in = ya;
        x_in = xb;
        if (y_in == 0 && x_in == 0) begin
            return '0;
        end
        if (y_in == 0 && x_in < 0) begin
            return HALF_TURN[OUT_W-1:0];
        end
        // rotate into the right half-plane first
        if (x_in < 0) begin
            if (y_in >= 0) begin
                x = y_in;
                y = -x_in;
                acc = ROT90_Q16;
            end else begin
                x = -y_in;
                y = x_in;
                acc = -ROT90_Q16;
            end
        end else begin
            x = x_in;
            y = y_in;
            acc = 0;
        end
        x = x <<< FRAC_BITS;
        y = y <<< FRAC_BITS;
        for (int i = 0; i < ITERS && i < ATAN_DEPTH; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                acc = acc + ATAN_STEP[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                acc = acc - ATAN_STEP[i];
            end
            x = nx;
            y = ny;
        end
        q = (acc + 256) >>> 9;
        if (q > HALF_TURN) begin
            q = HALF_TURN;
        end
        if (q < -HALF_TURN) begin
            q = -HALF_TURN;
        end
        return q[OUT_W-1:0];
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Entered and left at a falling edge.
    task automatic send_sample(input logic signed [AXIS_W-1:0] a,
                               input logic signed [AXIS_W-1:0] b);
        int gap;
        gap = src_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        samples_if.valid  <= 1'b1;
        samples_if.axis_a <= a;
        samples_if.axis_b <= b;
        do begin
            @(posedge clk);
        end while (!samples_if.ready);
        expected_angles.push_back(atan2_q7(a, b));
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic test_directed();
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd0, -16'sd1);
        send_sample(16'sd0, -16'sd32768);
        send_sample(16'sd0, 16'sd32767);
        send_sample(16'sd0, 16'sd1);
        send_sample(16'sd32767, 16'sd0);
        send_sample(-16'sd32768, 16'sd0);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(-16'sd32768, -16'sd32768);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(-16'sd32768, 16'sd32767);
        // just off the negative x axis, where saturation may kick in
        send_sample(16'sd1, -16'sd32768);
        send_sample(-16'sd1, -16'sd32768);
        send_sample(16'sd1, -16'sd1);
        send_sample(-16'sd1, -16'sd1);
        send_sample(16'sd1, 16'sd1);
        send_sample(-16'sd1, 16'sd1);
        send_sample(-16'sd32768, -16'sd1);
        send_sample(16'sd32767, -16'sd1);
        send_sample(-16'sd21846, 16'sd12345);
    endtask

    task automatic test_random_full(input int n);
        for (int k = 0; k < n; k++) begin
            send_sample(AXIS_W'($urandom), AXIS_W'($urandom));
        end
    endtask

    task automatic test_random_small(input int n);
        int a;
        int b;
        for (int k = 0; k < n; k++) begin
            a = $urandom_range(0, 16);
            b = $urandom_range(0, 16);
            send_sample(AXIS_W'(a - 8), AXIS_W'(b - 8));
        end
    endtask

    // vectors hugging the four axes, most of them around +-180
    task automatic test_near_axes(input int n);
        int big;
        int tiny;
        int which;
        for (int k = 0; k < n; k++) begin
            big = $urandom_range(1, 32768);
            tiny = $urandom_range(0, 8);
            tiny -= 4;
            which = $urandom_range(0, 9);
            if (which < 6) begin
                send_sample(AXIS_W'(tiny), AXIS_W'(-big));
            end else if (which < 7) begin
                send_sample(AXIS_W'(tiny), AXIS_W'(big - 1));
            end else if (which < 8) begin
                send_sample(AXIS_W'(big - 1), AXIS_W'(tiny));
            end else begin
                send_sample(AXIS_W'(-big), AXIS_W'(tiny));
            end
        end
    endtask

    task automatic test_back_to_back(input int n);
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        test_random_full(n);
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
    endtask

    // sink stops for a long stretch while words keep coming
    task automatic test_backpressure(input int n);
        src_idle_en = 1'b0;
        hold_req = 1'b1;
        test_random_full(n);
        src_idle_en = 1'b1;
    endtask

    // sink side: random stalls plus the long hold on request
    initial begin
        int stall_left;
        int hold_count;
        stall_left = 0;
        hold_count = 0;
        angles_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                angles_if.ready <= 1'b0;
                hold_count++;
                if (hold_count >= HOLD_CYCLES) begin
                    hold_count = 0;
                    hold_req = 1'b0;
                end
            end else if (stall_left > 0) begin
                angles_if.ready <= 1'b0;
                stall_left--;
            end else begin
                angles_if.ready <= 1'b1;
                if (snk_idle_en && $urandom_range(0, 99) < 20) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge clk) begin
        logic signed [OUT_W-1:0] want;
        if (rst_n && angles_if.valid && angles_if.ready) begin
            angles_checked++;
            if (expected_angles.size() == 0) begin
                $error("angle_deg_q7: unexpected word, actual %0d", angles_if.angle_deg_q7);
                errors++;
            end else begin
                want = expected_angles.pop_front();
                if (angles_if.angle_deg_q7 !== want) begin
                    $error("angle_deg_q7: expected %0d, actual %0d",
                           want, angles_if.angle_deg_q7);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((samples_if.valid && samples_if.ready) ||
                (angles_if.valid && angles_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles, %0d angles pending",
                         idle_cycles, expected_angles.size());
                $display("tilt_angle_atan2_degrees_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        errors = 0;
        samples_sent = 0;
        angles_checked = 0;
        idle_cycles = 0;
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        hold_req = 1'b0;
        rst_n = 1'b0;
        samples_if.valid = 1'b0;
        samples_if.axis_a = '0;
        samples_if.axis_b = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_full(450);
        test_random_small(150);
        test_near_axes(200);
        test_back_to_back(150);
        test_backpressure(120);
        test_random_full(50);

        samples_if.valid <= 1'b0;
        while (expected_angles.size() != 0) begin
            @(posedge clk);
        end
        repeat (PIPE_LAT + 8) @(posedge clk);

        $display("sent %0d sample pairs (directed, full range, small, near axes,", samples_sent);
        $display("back to back, long sink hold); %0d angles checked", angles_checked);
        if (errors == 0 && expected_angles.size() == 0) begin
            $display("tilt_angle_atan2_degrees_tb: PASS");
        end else begin
            $display("tilt_angle_atan2_degrees_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== tilt_angle_atan2_degrees.f =====
hw/rtl/tlt_pkg.sv
hw/rtl/tlt_in_if.sv
hw/rtl/tlt_out_if.sv
hw/rtl/tilt_angle_atan2_degrees.sv
sim/tilt_angle_atan2_degrees_tb.sv
